// ===== hw/rtl/rpn_pkg.sv =====
// rpn_pkg: types, codes and microprogram for the rpn stack calculator
// depends on nothing; imported by rpn_stack_calculator
package rpn_pkg;

  localparam int StackDepth = 16;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int DataW      = 32;
  localparam int DepthW     = 5;
  localparam int OpW        = 3;
  localparam int StatusW    = 3;
  localparam int UpcW       = 5;
  localparam int DivBits    = 2;                  // quotient bits per loop step
  localparam int DivendW    = DataW + 16;         // left operand scaled by 2^16
  localparam int DivSteps   = DivendW / DivBits;
  localparam int DivCntW    = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OpPush = 3'd0,
    OpAdd  = 3'd1,
    OpSub  = 3'd2,
    OpMul  = 3'd3,
    OpDiv  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk   = 3'd0,
    StFew  = 3'd1,
    StFull = 3'd2,
    StDiv0 = 3'd3,
    StSat  = 3'd4
  } status_e;

  // datapath action of one microinstruction
  typedef enum logic [3:0] {
    ActNone,
    ActPush,
    ActFew,
    ActLoad,
    ActAdd,
    ActSub,
    ActMul,
    ActMulFix,
    ActDivInit,
    ActDivStep,
    ActDivFix,
    ActWrBack,
    ActOut
  } act_e;

  // how the step counter moves on
  typedef enum logic [2:0] {
    CondNext,
    CondJump,
    CondDispatch,
    CondLoop,
    CondBZero,
    CondOutFree
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [UpcW-1:0] target;
  } ucode_t;

  localparam logic [UpcW-1:0] UpcIdle    = 5'd0;
  localparam logic [UpcW-1:0] UpcPush    = 5'd1;
  localparam logic [UpcW-1:0] UpcFew     = 5'd2;
  localparam logic [UpcW-1:0] UpcNop     = 5'd3;
  localparam logic [UpcW-1:0] UpcAdd     = 5'd4;
  localparam logic [UpcW-1:0] UpcAddExe  = 5'd5;
  localparam logic [UpcW-1:0] UpcSub     = 5'd6;
  localparam logic [UpcW-1:0] UpcSubExe  = 5'd7;
  localparam logic [UpcW-1:0] UpcMul     = 5'd8;
  localparam logic [UpcW-1:0] UpcMulExe  = 5'd9;
  localparam logic [UpcW-1:0] UpcMulFix  = 5'd10;
  localparam logic [UpcW-1:0] UpcDiv     = 5'd11;
  localparam logic [UpcW-1:0] UpcDivInit = 5'd12;
  localparam logic [UpcW-1:0] UpcDivLoop = 5'd13;
  localparam logic [UpcW-1:0] UpcDivFix  = 5'd14;
  localparam logic [UpcW-1:0] UpcWrBack  = 5'd15;
  localparam logic [UpcW-1:0] UpcOut     = 5'd16;

  function automatic ucode_t ucode_rom(logic [UpcW-1:0] upc);
    ucode_t w;
    unique case (upc)
      UpcIdle:    w = '{ActNone,    CondDispatch, UpcIdle};
      UpcPush:    w = '{ActPush,    CondJump,     UpcOut};
      UpcFew:     w = '{ActFew,     CondJump,     UpcOut};
      UpcNop:     w = '{ActNone,    CondJump,     UpcOut};
      UpcAdd:     w = '{ActLoad,    CondNext,     UpcIdle};
      UpcAddExe:  w = '{ActAdd,     CondJump,     UpcWrBack};
      UpcSub:     w = '{ActLoad,    CondNext,     UpcIdle};
      UpcSubExe:  w = '{ActSub,     CondJump,     UpcWrBack};
      UpcMul:     w = '{ActLoad,    CondNext,     UpcIdle};
      UpcMulExe:  w = '{ActMul,     CondNext,     UpcIdle};
      UpcMulFix:  w = '{ActMulFix,  CondJump,     UpcWrBack};
      UpcDiv:     w = '{ActLoad,    CondNext,     UpcIdle};
      UpcDivInit: w = '{ActDivInit, CondBZero,    UpcWrBack};
      UpcDivLoop: w = '{ActDivStep, CondLoop,     UpcDivLoop};
      UpcDivFix:  w = '{ActDivFix,  CondNext,     UpcIdle};
      UpcWrBack:  w = '{ActWrBack,  CondNext,     UpcIdle};
      UpcOut:     w = '{ActOut,     CondOutFree,  UpcIdle};
      default:    w = '{ActNone,    CondJump,     UpcIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/rpn_stack_calculator.sv =====
// rpn_stack_calculator: reverse-polish Q16.16 calculator on a 16-entry operand stack
// microcoded sequencer over a plain datapath; uses rpn_pkg
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one request: op_i and value_i.
//   op push stores value_i; add, subtract, multiply and divide pop the two top
//   entries (top is the right operand) and push the result.
//   output channel (out_valid_o/out_ready_i) returns one result per request:
//   status_o, top_value_o (zero when empty) and depth_o.
// timing:
//   one request at a time, stepped by the microprogram counter.
//   push, refused or unknown op: one step then output; add/sub: load, execute,
//   write back; multiply adds a fix-up step; divide is the worst case with 24
//   loop steps of a 2-bit-per-cycle restoring divider (none on divide by zero).
//   the next request is taken as soon as the sequencer is back in idle,
//   even while the previous result still sits in the output register.
// reset: stack empty, no result pending; stack entries are not cleared.
// stall: a finished result waits in the last microstep until the output
//   register is free, so no result is lost or repeated.
module rpn_stack_calculator
  import rpn_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OpW-1:0]            op_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic signed [DataW-1:0]   top_value_o,
  output logic [DepthW-1:0]         depth_o
);

  localparam logic [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

  logic [DataW-1:0]   stack_mem [StackDepth];
  logic [DataW-1:0]   rd_q;

  logic [UpcW-1:0]    upc_q, upc_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q;
  logic [DataW-1:0]   out_top_q;
  logic [DepthW-1:0]  out_depth_q;

  logic [DataW-1:0]   val_q, top_q, top_d, a_q, b_q, res_q, res_d;
  logic [2*DataW-1:0] p_q;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DivendW-1:0] dq_q, dq_d;
  logic [DivCntW-1:0] div_cnt_q;
  logic               neg_q;
  status_e            status_q, status_d;

  ucode_t             uw;
  logic               accept, out_free, full, few;
  logic [PtrW-1:0]    rd_addr, wr_addr;
  logic               wr_en;
  logic [DataW-1:0]   wr_data;
  logic [DataW:0]     sum;
  logic [DataW-1:0]   a_mag, b_mag;
  logic [DataW:0]     trial;

  assign uw       = ucode_rom(upc_q);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (cnt_q >= CntW'(StackDepth));
  assign few      = (cnt_q < CntW'(2));
  assign rd_addr  = PtrW'(cnt_q - CntW'(2));

  assign in_ready_o = (upc_q == UpcIdle);

  // step counter
  always_comb begin
    upc_d = upc_q;
    unique case (uw.cond)
      CondNext: upc_d = upc_q + UpcW'(1);
      CondJump: upc_d = uw.target;
      CondDispatch: begin
        if (accept) begin
          unique case (op_i)
            OpPush:                    upc_d = UpcPush;
            OpAdd:                     upc_d = few ? UpcFew : UpcAdd;
            OpSub:                     upc_d = few ? UpcFew : UpcSub;
            OpMul:                     upc_d = few ? UpcFew : UpcMul;
            OpDiv:                     upc_d = few ? UpcFew : UpcDiv;
            default:                   upc_d = UpcNop;
          endcase
        end
      end
      CondLoop:    upc_d = (div_cnt_q != '0) ? uw.target : upc_q + UpcW'(1);
      CondBZero:   upc_d = (b_q == '0) ? uw.target : upc_q + UpcW'(1);
      CondOutFree: upc_d = out_free ? uw.target : upc_q;
      default:     upc_d = UpcIdle;
    endcase
  end

  // add/subtract with saturation
  always_comb begin
    if (uw.act == ActSub) begin
      sum = {a_q[DataW-1], a_q} - {b_q[DataW-1], b_q};
    end else begin
      sum = {a_q[DataW-1], a_q} + {b_q[DataW-1], b_q};
    end
  end

  assign a_mag = a_q[DataW-1] ? DataW'(-a_q) : a_q;
  assign b_mag = b_q[DataW-1] ? DataW'(-b_q) : b_q;

  // two restoring division bits per step
  always_comb begin
    logic [DataW-1:0]   r;
    logic [DivendW-1:0] d;
    r = rem_q;
    d = dq_q;
    trial = '0;
    for (int i = 0; i < DivBits; i++) begin
      trial = {r, d[DivendW-1]} - {1'b0, b_q};
      d = {d[DivendW-2:0], 1'b0};
      if (!trial[DataW]) begin
        r    = trial[DataW-1:0];
        d[0] = 1'b1;
      end else begin
        r = {r[DataW-2:0], dq_q[DivendW-1-i]};
      end
    end
    rem_d = r;
    dq_d  = d;
  end

  // datapath results and stack write
  always_comb begin
    res_d    = res_q;
    status_d = status_q;
    top_d    = top_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_addr  = rd_addr;
    wr_data  = res_q;
    if (accept) begin
      status_d = StOk;
    end
    unique case (uw.act) inside
      ActPush: begin
        if (full) begin
          status_d = StFull;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[PtrW-1:0];
          wr_data = val_q;
          top_d   = val_q;
          cnt_d   = cnt_q + CntW'(1);
        end
      end
      ActFew: status_d = StFew;
      ActAdd, ActSub: begin
        if (sum[DataW] != sum[DataW-1]) begin
          res_d    = sum[DataW] ? QMin : QMax;
          status_d = StSat;
        end else begin
          res_d = sum[DataW-1:0];
        end
      end
      ActMulFix: begin
        // product >>> 16 fits when bits 63..47 all agree
        if ((p_q[2*DataW-1:DataW+15] != '0) && (p_q[2*DataW-1:DataW+15] != '1)) begin
          res_d    = p_q[2*DataW-1] ? QMin : QMax;
          status_d = StSat;
        end else begin
          res_d = p_q[DataW+15:16];
        end
      end
      ActDivInit: begin
        if (b_q == '0) begin
          res_d    = a_q[DataW-1] ? QMin : QMax;
          status_d = StDiv0;
        end
      end
      ActDivFix: begin
        if (!neg_q) begin
          if (dq_q[DivendW-1:DataW-1] != '0) begin
            res_d    = QMax;
            status_d = StSat;
          end else begin
            res_d = dq_q[DataW-1:0];
          end
        end else begin
          if ((dq_q[DivendW-1:DataW] != '0) ||
              (dq_q[DataW-1] && (dq_q[DataW-2:0] != '0))) begin
            res_d    = QMin;
            status_d = StSat;
          end else begin
            res_d = DataW'(-dq_q[DataW-1:0]);
          end
        end
      end
      ActWrBack: begin
        wr_en   = 1'b1;
        wr_addr = rd_addr;
        wr_data = res_q;
        top_d   = res_q;
        cnt_d   = cnt_q - CntW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_d = (uw.act == ActOut && out_free) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  // operand stack memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpcIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StOk;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= value_i;
    end
    top_q <= top_d;
    res_q <= res_d;
    unique case (uw.act)
      ActLoad: begin
        a_q <= rd_q;
        b_q <= top_q;
      end
      ActMul: p_q <= $signed(a_q) * $signed(b_q);
      ActDivInit: begin
        neg_q     <= a_q[DataW-1] ^ b_q[DataW-1];
        rem_q     <= '0;
        dq_q      <= {a_mag, 16'b0};
        b_q       <= b_mag;
        div_cnt_q <= DivCntW'(DivSteps - 1);
      end
      ActDivStep: begin
        rem_q     <= rem_d;
        dq_q      <= dq_d;
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end
      default: ;
    endcase
    if (uw.act == ActOut && out_free) begin
      out_status_q <= status_q;
      out_top_q    <= (cnt_q == '0) ? '0 : top_q;
      out_depth_q  <= DepthW'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;

  // stack never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth))
    else $error("stack count above depth");

  // depth only moves in the push and write-back steps
  a_cnt_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q != UpcPush && upc_q != UpcWrBack) |=> $stable(cnt_q))
    else $error("stack count changed outside push or write-back");

  // an accepted request starts the microprogram
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> upc_q != UpcIdle)
    else $error("request accepted but sequencer stayed idle");

  // a result is only loaded when the output register is free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UpcOut && !out_free) |=> upc_q == UpcOut)
    else $error("result step left while output stalled");

endmodule
